FILE: hdl/mdt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdt_pkg
// Shared types and constants for the multi-delimiter tokenizer.
// ----------------------------------------------------------------------------
package mdt_pkg;

  // Configuration register indexes
  localparam int unsigned NumTextRegs = 6;
  localparam logic [2:0]  RegSepLengths = 3'd6;
  localparam logic [2:0]  RegSepCount   = 3'd7;

  // Queue between front end and engine (power of two)
  localparam int unsigned QueueDepth = 4;

  // Saturation limit of the token counter
  localparam logic [15:0] IndexMax = 16'hFFFF;

  // Operation of one queued request
  typedef enum logic [1:0] {
    OP_BYTE     = 2'd0,  // character, string continues
    OP_BYTE_END = 2'd1,  // character, last of the string
    OP_END      = 2'd2   // end of string without character
  } mdt_op_e;

  // Kind of one result
  typedef enum logic [1:0] {
    KIND_BYTE       = 2'd0,
    KIND_TOKEN_END  = 2'd1,
    KIND_STRING_END = 2'd2
  } mdt_kind_e;

  typedef struct packed {
    mdt_op_e    op;
    logic [7:0] data;
  } mdt_item_t;

  typedef struct packed {
    logic [NumTextRegs-1:0][63:0] text;
    logic [23:0]                  lens;
    logic [2:0]                   cnt;
  } mdt_cfg_t;

endpackage
`default_nettype wire

FILE: hdl/multi_delimiter_tokenizer.sv
// A character request passes the queue and then the lookahead window; the engine
//   decides on the window front and writes the result into the output register.
// Character requests are taken at one per cycle while the output is not stalled
//   and no string is being closed; an end-of-string request is followed by at most
//   one front decision per byte left in the lookahead window (up to MAX_SEP_LEN),
//   then one or two closing marks, all through the single engine.
// Reset: asynchronous, active low; clears all but the lookahead window and queue storage.
`default_nettype none
// ----------------------------------------------------------------------------
// multi_delimiter_tokenizer
// Splits a byte stream into tokens at any of up to six configured
// multi-byte separators.
// ----------------------------------------------------------------------------
module multi_delimiter_tokenizer import mdt_pkg::*; #(
  parameter int unsigned MAX_SEP_LEN = 8,
  parameter int unsigned NUM_SEPS    = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        byte_valid_i,
  input  wire logic        string_end_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       out_byte_o,
  output logic [15:0]      token_index_o,
  output logic             run_last_o
);

  mdt_cfg_t   cfg_q;
  logic       q_full;
  logic       q_push;
  mdt_item_t  q_wr_item;
  logic       q_valid;
  logic       q_pop;
  mdt_item_t  q_rd_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSepLengths: cfg_q.lens <= cfg_data_i[23:0];
        RegSepCount:   cfg_q.cnt  <= cfg_data_i[2:0];
        default:       cfg_q.text[cfg_index_i] <= cfg_data_i;
      endcase
    end
  end

  mdt_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .byte_valid_i (byte_valid_i),
    .string_end_i (string_end_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (q_wr_item)
  );

  mdt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_rd_item)
  );

  mdt_back #(
    .MAX_SEP_LEN (MAX_SEP_LEN),
    .NUM_SEPS    (NUM_SEPS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_rd_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .token_index_o (token_index_o),
    .run_last_o    (run_last_o)
  );

endmodule
`default_nettype wire

FILE: hdl/mdt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdt_front
// Accepts input requests, drops empty ones and classifies the rest into
// queue operations.
// ----------------------------------------------------------------------------
module mdt_front import mdt_pkg::*; (
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       byte_valid_i,
  input  wire logic       string_end_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output mdt_item_t       q_item_o
);

  // Stall while the queue has no room
  assign in_stall_o = q_full_i;

  // An item with neither character nor end mark does nothing
  assign q_push_o = in_valid_i && !q_full_i && (byte_valid_i || string_end_i);

  always_comb begin
    q_item_o.data = in_byte_i;
    if (!byte_valid_i) begin
      q_item_o.op = OP_END;
    end else if (string_end_i) begin
      q_item_o.op = OP_BYTE_END;
    end else begin
      q_item_o.op = OP_BYTE;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mdt_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdt_fifo
// Short request queue that decouples the front end from the engine.
// ----------------------------------------------------------------------------
module mdt_fifo import mdt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  mdt_item_t      item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output mdt_item_t      item_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  mdt_item_t          mem_q [QueueDepth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]      count_q;

  assign full_o  = (count_q == (PtrW+1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mdt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdt_back
// Tokenizer engine: lookahead window, separator match, token bookkeeping,
// end-of-string flush and the output register.
// ----------------------------------------------------------------------------
module mdt_back import mdt_pkg::*; #(
  parameter int unsigned MAX_SEP_LEN = 8,
  parameter int unsigned NUM_SEPS    = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  mdt_cfg_t         cfg_i,
  input  wire logic        q_valid_i,
  input  mdt_item_t        q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       out_byte_o,
  output logic [15:0]      token_index_o,
  output logic             run_last_o
);

  localparam int unsigned WinW  = MAX_SEP_LEN * 8;
  localparam int unsigned FillW = $clog2(MAX_SEP_LEN + 1);
  localparam logic [FillW-1:0] FullFill = FillW'(MAX_SEP_LEN);
  localparam logic [FillW-1:0] LastFill = FillW'(MAX_SEP_LEN - 1);
  localparam logic [3:0] MaxLen = 4'(MAX_SEP_LEN);
  localparam logic [2:0] MaxSeps = 3'(NUM_SEPS);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_EOS
  } state_e;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == IndexMax) ? v : v + 16'd1;
  endfunction

  state_e             state_q, state_d;
  logic [WinW-1:0]    la_q, la_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic               in_tok_q, in_tok_d;
  logic [15:0]        tok_q, tok_d;
  logic               seen_q, seen_d;

  logic               out_vld_q;
  mdt_kind_e          out_kind_q;
  logic [7:0]         out_byte_q;
  logic [15:0]        out_idx_q;
  logic               out_last_q;

  logic               step;
  logic               emit;
  mdt_kind_e          o_kind;
  logic [7:0]         o_byte;
  logic [15:0]        o_idx;
  logic               o_last;

  logic [WinW-1:0]    ins_win;
  logic [WinW-1:0]    dec_win;
  logic [FillW-1:0]   dec_fill;
  logic [3:0]         match_len;
  logic [FillW-1:0]   dec_drop;
  logic [WinW-1:0]    dec_rest;
  logic               dec_emit;
  mdt_kind_e          dec_kind;
  logic               dec_in_tok;
  logic [15:0]        dec_tok;

  // Engine moves only when the output register is free or being drained
  assign step = !out_vld_q || !out_stall_i;

  // Window with the incoming character placed at the fill position
  assign ins_win = (la_q & ~(WinW'(8'hFF) << {fill_q, 3'b000}))
                 | (WinW'(q_item_i.data) << {fill_q, 3'b000});

  // Decision sees the full window with the new byte, or the stored one
  assign dec_win  = (state_q == ST_RUN) ? ins_win : la_q;
  assign dec_fill = (state_q == ST_RUN) ? FullFill : fill_q;

  // Separator match at the window front, lowest index wins
  always_comb begin
    logic [2:0] used;
    logic [3:0] len_k;
    logic       hit;
    used      = (cfg_i.cnt > MaxSeps) ? MaxSeps : cfg_i.cnt;
    match_len = '0;
    for (int k = NUM_SEPS - 1; k >= 0; k--) begin
      len_k = cfg_i.lens[4*k +: 4];
      if (len_k > MaxLen) begin
        len_k = MaxLen;
      end
      hit = (3'(k) < used) && (len_k != 4'd0) && (len_k <= 4'(dec_fill));
      for (int i = 0; i < MAX_SEP_LEN; i++) begin
        if ((4'(i) < len_k) && (dec_win[8*i +: 8] != cfg_i.text[k][8*i +: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        match_len = len_k;
      end
    end
  end

  // One front decision: skip a separator (closing an open token) or emit the front character
  always_comb begin
    if (match_len != 4'd0) begin
      dec_emit   = in_tok_q;
      dec_kind   = KIND_TOKEN_END;
      dec_drop   = FillW'(match_len);
      dec_in_tok = 1'b0;
      dec_tok    = in_tok_q ? sat_inc(tok_q) : tok_q;
    end else begin
      dec_emit   = 1'b1;
      dec_kind   = KIND_BYTE;
      dec_drop   = FillW'(1);
      dec_in_tok = 1'b1;
      dec_tok    = tok_q;
    end
    dec_rest = dec_win >> {dec_drop, 3'b000};
  end

  // Next state
  always_comb begin
    state_d  = state_q;
    la_d     = la_q;
    fill_d   = fill_q;
    in_tok_d = in_tok_q;
    tok_d    = tok_q;
    seen_d   = seen_q;
    q_pop_o  = 1'b0;
    emit     = 1'b0;
    o_kind   = KIND_BYTE;
    o_byte   = 8'd0;
    o_idx    = tok_q;
    o_last   = 1'b0;

    case (state_q)
      ST_RUN: begin
        if (step && q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_item_i.op)
            OP_BYTE: begin
              seen_d = 1'b1;
              if (fill_q == LastFill) begin
                // window becomes full: decide on the front right away
                la_d     = dec_rest;
                fill_d   = FullFill - dec_drop;
                in_tok_d = dec_in_tok;
                tok_d    = dec_tok;
                emit     = dec_emit;
                o_kind   = dec_kind;
                o_byte   = (dec_kind == KIND_BYTE) ? dec_win[7:0] : 8'd0;
                o_last   = 1'b1;
              end else begin
                la_d   = ins_win;
                fill_d = fill_q + 1'b1;
              end
            end
            OP_BYTE_END: begin
              seen_d  = 1'b1;
              la_d    = ins_win;
              fill_d  = fill_q + 1'b1;
              state_d = ST_FLUSH;
            end
            OP_END: begin
              state_d = ST_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end

      ST_FLUSH: begin
        if (step) begin
          if (fill_q != '0) begin
            la_d     = dec_rest;
            fill_d   = fill_q - dec_drop;
            in_tok_d = dec_in_tok;
            tok_d    = dec_tok;
            emit     = dec_emit;
            o_kind   = dec_kind;
            o_byte   = (dec_kind == KIND_BYTE) ? dec_win[7:0] : 8'd0;
          end else if (in_tok_q || !seen_q) begin
            // close the open token, or the single empty token
            emit     = 1'b1;
            o_kind   = KIND_TOKEN_END;
            o_idx    = in_tok_q ? tok_q : 16'd0;
            tok_d    = in_tok_q ? sat_inc(tok_q) : 16'd1;
            in_tok_d = 1'b0;
            state_d  = ST_EOS;
          end else begin
            emit     = 1'b1;
            o_kind   = KIND_STRING_END;
            o_last   = 1'b1;
            tok_d    = 16'd0;
            seen_d   = 1'b0;
            state_d  = ST_RUN;
          end
        end
      end

      ST_EOS: begin
        if (step) begin
          emit     = 1'b1;
          o_kind   = KIND_STRING_END;
          o_last   = 1'b1;
          fill_d   = '0;
          in_tok_d = 1'b0;
          tok_d    = 16'd0;
          seen_d   = 1'b0;
          state_d  = ST_RUN;
        end
      end

      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // Lookahead window, no reset needed
  always_ff @(posedge clk_i) begin
    la_q <= la_d;
  end

  // State and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      fill_q     <= '0;
      in_tok_q   <= 1'b0;
      tok_q      <= 16'd0;
      seen_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      out_kind_q <= KIND_BYTE;
      out_byte_q <= 8'd0;
      out_idx_q  <= 16'd0;
      out_last_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      in_tok_q <= in_tok_d;
      tok_q    <= tok_d;
      seen_q   <= seen_d;
      if (step) begin
        out_vld_q <= emit;
        if (emit) begin
          out_kind_q <= o_kind;
          out_byte_q <= o_byte;
          out_idx_q  <= o_idx;
          out_last_q <= o_last;
        end
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign kind_o        = out_kind_q;
  assign out_byte_o    = out_byte_q;
  assign token_index_o = out_idx_q;
  assign run_last_o    = out_last_q;

  // While waiting for a request the window is never full
  a_run_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (fill_q < FullFill))
    else $error("window full while waiting for a request");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullFill)
    else $error("window fill out of range");

  // Closing mark only after the window is drained and the token closed
  a_eos_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EOS) |-> (fill_q == '0 && !in_tok_q))
    else $error("end of string with data left");

  a_eos_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q == KIND_STRING_END) |-> out_last_q)
    else $error("end of string not marked last");

endmodule
`default_nettype wire
